// ===== rtl/paged_intel_hex_encoder_core_defines.svh =====
// Assertion macros for the paged Intel HEX encoder core.
`ifndef PAGED_INTEL_HEX_ENCODER_CORE_DEFINES_SVH
`define PAGED_INTEL_HEX_ENCODER_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked out of reset.
`define PHEX_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("phex assertion failed");

// Next-cycle implication, checked out of reset.
`define PHEX_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("phex assertion failed");

`else

`define PHEX_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define PHEX_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/phex_pkg.sv =====
// Shared types, constants and helpers for the paged Intel HEX encoder.
`default_nettype none

package phex_pkg;

  localparam int BYTES_PER_RECORD = 32;
  localparam int RECORDS_PER_PAGE = 512;

  localparam int REC_AW  = $clog2(BYTES_PER_RECORD);
  localparam int FILL_W  = $clog2(BYTES_PER_RECORD + 1);
  localparam int RIP_W   = $clog2(RECORDS_PER_PAGE);

  localparam logic [15:0] BASE_RESET  = 16'h4000;
  localparam logic [15:0] ADDR_STEP   = 16'h0020;
  localparam logic [7:0]  PAGE_CS_ADD = 8'h04;

  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_TWO   = 8'h32;
  localparam logic [7:0] CH_F     = 8'h46;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  // one character from the sequencer to the word packer
  typedef struct packed {
    logic       valid;
    logic [7:0] code;
    logic       last;   // last character of this input word's text
    logic       done;   // last character of the end-of-file record
  } char_beat_t;

  // record store access
  typedef struct packed {
    logic              we;
    logic [REC_AW-1:0] waddr;
    logic [7:0]        wdata;
    logic              re;
    logic [REC_AW-1:0] raddr;
  } store_req_t;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] offs;
    offs = (nib < 4'd10) ? CH_ZERO : 8'h37;
    return {4'h0, nib} + offs;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/phex_store.sv =====
// Record byte store: one write port, one registered read port.
`default_nettype none

module phex_store
  import phex_pkg::*;
(
  input  wire logic       clk,
  input  wire store_req_t req,
  output logic [7:0]      rd_data
);

  logic [7:0] mem [BYTES_PER_RECORD];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (req.re) begin
      rd_data <= mem[req.raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/phex_seq.sv =====
// Record sequencer: takes bytes, tracks record/page state, emits text characters.
`default_nettype none

module phex_seq
  import phex_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_byte,
  input  wire logic        in_final,
  input  wire logic [15:0] page_base,
  output store_req_t       st_req,
  input  wire logic [7:0]  st_rd_data,
  output char_beat_t       ch,
  input  wire logic        ch_ready
);

  localparam int IDX_W = 5;

  typedef enum logic [2:0] {
    S_IDLE, S_PAGE, S_HEAD, S_DATA, S_TAIL, S_EOF
  } state_t;

  state_t            state;
  logic [IDX_W-1:0]  idx;
  logic [REC_AW-1:0] byte_idx;
  logic              nib;
  logic              fin;
  logic [FILL_W-1:0] fill_count;
  logic [7:0]        data_sum;
  logic [15:0]       record_address;
  logic [RIP_W-1:0]  record_in_page;
  logic [15:0]       page_number;

  logic              accept, adv;
  logic [FILL_W-1:0] fill_next;
  logic              rec_full;
  logic [7:0]        cnt8, rsum, rcs, pcs;
  logic              data_end;

  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign fill_next = fill_count + FILL_W'(1);
  assign rec_full  = (fill_next == FILL_W'(BYTES_PER_RECORD));
  assign adv       = ch.valid && ch_ready;

  assign cnt8     = 8'(fill_count);
  assign rsum     = record_address[15:8] + record_address[7:0] + data_sum + cnt8;
  assign rcs      = 8'd0 - rsum;
  assign pcs      = 8'd0 - (PAGE_CS_ADD + page_number[7:0]);
  assign data_end = (FILL_W'(byte_idx) == fill_count - FILL_W'(1));

  always_comb begin
    st_req.we    = accept;
    st_req.waddr = fill_count[REC_AW-1:0];
    st_req.wdata = in_byte;
    st_req.re    = adv && (((state == S_HEAD) && (idx == IDX_W'(8))) ||
                           ((state == S_DATA) && nib));
    st_req.raddr = (state == S_HEAD) ? '0 : byte_idx + REC_AW'(1);
  end

  // character for the current position
  always_comb begin
    ch.valid = (state != S_IDLE);
    ch.code  = CH_ZERO;
    ch.last  = 1'b0;
    ch.done  = 1'b0;
    case (state)
      S_PAGE: begin
        case (idx)
          IDX_W'(0):  ch.code = CH_COLON;
          IDX_W'(2),
          IDX_W'(8):  ch.code = CH_TWO;
          IDX_W'(9):  ch.code = hex_char(page_number[15:12]);
          IDX_W'(10): ch.code = hex_char(page_number[11:8]);
          IDX_W'(11): ch.code = hex_char(page_number[7:4]);
          IDX_W'(12): ch.code = hex_char(page_number[3:0]);
          IDX_W'(13): ch.code = hex_char(pcs[7:4]);
          IDX_W'(14): ch.code = hex_char(pcs[3:0]);
          IDX_W'(15): ch.code = CH_CR;
          IDX_W'(16): ch.code = CH_LF;
          default:    ch.code = CH_ZERO;
        endcase
      end
      S_HEAD: begin
        case (idx)
          IDX_W'(0): ch.code = CH_COLON;
          IDX_W'(1): ch.code = hex_char(cnt8[7:4]);
          IDX_W'(2): ch.code = hex_char(cnt8[3:0]);
          IDX_W'(3): ch.code = hex_char(record_address[15:12]);
          IDX_W'(4): ch.code = hex_char(record_address[11:8]);
          IDX_W'(5): ch.code = hex_char(record_address[7:4]);
          IDX_W'(6): ch.code = hex_char(record_address[3:0]);
          default:   ch.code = CH_ZERO;
        endcase
      end
      S_DATA: begin
        ch.code = nib ? hex_char(st_rd_data[3:0]) : hex_char(st_rd_data[7:4]);
      end
      S_TAIL: begin
        case (idx)
          IDX_W'(0): ch.code = hex_char(rcs[7:4]);
          IDX_W'(1): ch.code = hex_char(rcs[3:0]);
          IDX_W'(2): ch.code = CH_CR;
          default:   ch.code = CH_LF;
        endcase
        ch.last = (idx == IDX_W'(3)) && !fin;
      end
      S_EOF: begin
        case (idx)
          IDX_W'(0):  ch.code = CH_COLON;
          IDX_W'(8):  ch.code = CH_ONE;
          IDX_W'(9),
          IDX_W'(10): ch.code = CH_F;
          default:    ch.code = CH_ZERO;
        endcase
        ch.last = (idx == IDX_W'(10));
        ch.done = (idx == IDX_W'(10));
      end
      default: begin
        ch.code = CH_ZERO;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      idx            <= '0;
      byte_idx       <= '0;
      nib            <= 1'b0;
      fin            <= 1'b0;
      fill_count     <= '0;
      data_sum       <= '0;
      record_address <= BASE_RESET;
      record_in_page <= '0;
      page_number    <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            fill_count <= fill_next;
            data_sum   <= data_sum + in_byte;
            fin        <= in_final;
            idx        <= '0;
            if (rec_full || in_final) begin
              state <= (record_in_page == '0) ? S_PAGE : S_HEAD;
            end
          end
        end
        S_PAGE: begin
          if (adv) begin
            if (idx == IDX_W'(16)) begin
              state          <= S_HEAD;
              idx            <= '0;
              page_number    <= page_number + 16'd1;
              record_address <= page_base;
            end else begin
              idx <= idx + IDX_W'(1);
            end
          end
        end
        S_HEAD: begin
          if (adv) begin
            if (idx == IDX_W'(8)) begin
              state    <= S_DATA;
              byte_idx <= '0;
              nib      <= 1'b0;
            end else begin
              idx <= idx + IDX_W'(1);
            end
          end
        end
        S_DATA: begin
          if (adv) begin
            if (!nib) begin
              nib <= 1'b1;
            end else if (data_end) begin
              state <= S_TAIL;
              idx   <= '0;
            end else begin
              nib      <= 1'b0;
              byte_idx <= byte_idx + REC_AW'(1);
            end
          end
        end
        S_TAIL: begin
          if (adv) begin
            if (idx == IDX_W'(3)) begin
              state          <= fin ? S_EOF : S_IDLE;
              idx            <= '0;
              record_address <= record_address + ADDR_STEP;
              record_in_page <= (record_in_page == RIP_W'(RECORDS_PER_PAGE - 1)) ?
                                '0 : record_in_page + RIP_W'(1);
              fill_count     <= '0;
              data_sum       <= '0;
            end else begin
              idx <= idx + IDX_W'(1);
            end
          end
        end
        S_EOF: begin
          if (adv) begin
            if (idx == IDX_W'(10)) begin
              state          <= S_IDLE;
              idx            <= '0;
              fill_count     <= '0;
              data_sum       <= '0;
              record_in_page <= '0;
              page_number    <= '0;
              record_address <= page_base;
            end else begin
              idx <= idx + IDX_W'(1);
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/phex_pack.sv =====
// Word packer: gathers characters into 4-character words behind an output register.
`default_nettype none

module phex_pack
  import phex_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire char_beat_t ch,
  output logic            ch_ready,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [31:0]     out_chars,
  output logic [2:0]      out_count,
  output logic            out_last,
  output logic            out_done
);

  logic [7:0]  held [3];
  logic [1:0]  cnt;
  logic        out_free, push, take;
  logic [31:0] word;

  assign out_free = !out_valid || out_ready;
  assign push     = (cnt == 2'd3) || ch.last;
  assign ch_ready = !push || out_free;
  assign take     = ch.valid && ch_ready;

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      if (j < 3 && 2'(j) < cnt) begin
        word[8*j +: 8] = held[j < 3 ? j : 0];
      end else if (3'(j) == {1'b0, cnt}) begin
        word[8*j +: 8] = ch.code;
      end else begin
        word[8*j +: 8] = 8'h00;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (take && push) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (take) begin
        cnt <= push ? 2'd0 : cnt + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && !push) begin
      held[cnt] <= ch.code;
    end
    if (take && push) begin
      out_chars <= word;
      out_count <= {1'b0, cnt} + 3'd1;
      out_last  <= ch.last;
      out_done  <= ch.done;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/paged_intel_hex_encoder_core.sv =====
// Top level of the paged Intel HEX encoder: binary bytes in, packed ASCII words out.
//
//  channel  | dir | words                  | contents
//  ---------+-----+------------------------+-------------------------------------------
//  s_axis   | in  | one image byte         | tdata[7:0] data_byte, tlast final_byte
//  m_axis   | out | up to 4 ASCII chars    | tdata chars a..d, char_count; tlast run_last;
//           |     |                        | tuser file_done
//  cfg      | in  | page base write        | cfg_data[15:0]
//
// A byte that completes no record is taken and gives no word.
// A byte that closes a record is taken, then the sequencer emits its text one
// character at a time as the word packer takes them: 17 characters for the
// page header (first record of a page), 13 + 2*n for an n-byte data record
// and 11 for the end-of-file record.
// s_axis_tready is high only while the sequencer is idle; a held output word
// stalls the sequencer, not the last finished word, which waits in m_axis.
// rst is synchronous, active high; the page base resets to 0x4000.
`default_nettype none

`include "paged_intel_hex_encoder_core_defines.svh"

module paged_intel_hex_encoder_core
  import phex_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,

  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  wire logic        s_axis_tlast,   // final_byte

  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,   // [7:0] a, [15:8] b, [23:16] c, [31:24] d,
                                           // [34:32] char_count, [39:35] zero
  output logic             m_axis_tlast,   // run_last
  output logic [0:0]       m_axis_tuser,   // [0] file_done

  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_data        // page base
);

  logic [15:0] page_base;
  store_req_t  st_req;
  logic [7:0]  st_rd_data;
  char_beat_t  ch;
  logic        ch_ready;
  logic [31:0] out_chars;
  logic [2:0]  out_count;
  logic        out_done;

  // register write is always taken; it only matters at the next page start
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      page_base <= BASE_RESET;
    end else if (cfg_valid) begin
      page_base <= cfg_data;
    end
  end

  phex_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_byte    (s_axis_tdata),
    .in_final   (s_axis_tlast),
    .page_base  (page_base),
    .st_req     (st_req),
    .st_rd_data (st_rd_data),
    .ch         (ch),
    .ch_ready   (ch_ready)
  );

  // record bytes live here; reads trail the writes of the same record
  phex_store u_store (
    .clk     (clk),
    .req     (st_req),
    .rd_data (st_rd_data)
  );

  phex_pack u_pack (
    .clk       (clk),
    .rst       (rst),
    .ch        (ch),
    .ch_ready  (ch_ready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_chars (out_chars),
    .out_count (out_count),
    .out_last  (m_axis_tlast),
    .out_done  (out_done)
  );

  assign m_axis_tdata = {5'd0, out_count, out_chars};
  assign m_axis_tuser = out_done;

  // idle sequencer never offers a character
  `PHEX_ASSERT_IMPLY(a_idle_quiet, clk, rst, s_axis_tready, !ch.valid)
  // a word that ends the file also ends its run
  `PHEX_ASSERT_IMPLY(a_done_last, clk, rst, m_axis_tvalid && m_axis_tuser[0], m_axis_tlast)
  // character count of a shown word is 1 to 4
  `PHEX_ASSERT_IMPLY(a_count_range, clk, rst, m_axis_tvalid,
                     m_axis_tdata[34:32] != 3'd0 && m_axis_tdata[34:32] <= 3'd4)
  // a final byte always starts text, so input closes next cycle
  `PHEX_ASSERT_NEXT(a_final_busy, clk, rst,
                    s_axis_tvalid && s_axis_tready && s_axis_tlast, !s_axis_tready)

endmodule

`default_nettype wire

// ===== tb/sv/tb_paged_intel_hex_encoder_core.sv =====
// Self-checking testbench for the paged Intel HEX encoder core: random byte images in, text words checked.
module tb_paged_intel_hex_encoder_core;
  import phex_pkg::*;

  // Run limit. Even if every byte made 27 words, each waiting out 78%
  // receiver stalls, plus the long hold-off and the settle gaps, a correct
  // run stays under this limit.
  localparam int unsigned LIMIT       = 300_000;
  // Quiet cycles before a register write or the end. The longest text
  // burst of one byte is header + full record + end-of-file, ~105 chars.
  localparam int unsigned SETTLE      = 150;
  localparam int unsigned HOLD_LEN    = 400;    // long receiver hold-off
  localparam int unsigned PHASE_BYTES = 80;     // random bytes per idling phase
  localparam int unsigned MID_HEAD    = 40;     // mid-file base test, before the write
  localparam int unsigned MID_TAIL    = 10;     // mid-file base test, after it

  typedef struct {
    logic [39:0] data;
    logic        last;
    logic        done;
  } hex_word_t;

  // Holds its own copy of the encoder state and the queue of text words
  // that the accepted bytes must produce, oldest first.
  class hex_line_scoreboard;
    logic [15:0] base_addr;
    logic [7:0]  rec_buf [BYTES_PER_RECORD];
    int unsigned fill;
    logic [15:0] rec_addr;
    logic [7:0]  byte_sum;
    int unsigned rec_in_page;
    logic [15:0] page_num;
    logic [7:0]  line_text [$];
    hex_word_t   expected_words [$];
    int          errors;

    function new();
      base_addr = BASE_RESET;
      errors    = 0;
      start_file();
    endfunction

    function void start_file();
      fill        = 0;
      byte_sum    = 8'h00;
      rec_in_page = 0;
      page_num    = 16'h0000;
      rec_addr    = base_addr;
    endfunction

    function void set_base(logic [15:0] value);
      base_addr = value;
    endfunction

    function void put_str(string s);
      for (int i = 0; i < s.len(); i++) line_text.push_back(s[i]);
    endfunction

    function void put_hex8(logic [7:0] v);
      string digits = "0123456789ABCDEF";
      line_text.push_back(digits[v[7:4]]);
      line_text.push_back(digits[v[3:0]]);
    endfunction

    function void put_eol();
      line_text.push_back(CH_CR);
      line_text.push_back(CH_LF);
    endfunction

    function void emit_record();
      logic [7:0] csum;
      // page header ahead of the first record of a page; base reloads here
      if (rec_in_page == 0) begin
        put_str(":02000002");
        put_hex8(page_num[15:8]);
        put_hex8(page_num[7:0]);
        put_hex8(8'h00 - PAGE_CS_ADD - page_num[7:0]);
        put_eol();
        page_num = page_num + 16'd1;
        rec_addr = base_addr;
      end
      put_str(":");
      put_hex8(8'(fill));
      put_hex8(rec_addr[15:8]);
      put_hex8(rec_addr[7:0]);
      put_str("00");
      for (int i = 0; i < fill; i++) put_hex8(rec_buf[i]);
      csum = 8'h00 - (rec_addr[15:8] + rec_addr[7:0] + byte_sum + 8'(fill));
      put_hex8(csum);
      put_eol();
      rec_addr    = rec_addr + ADDR_STEP;  // wraps mod 2^16
      rec_in_page = (rec_in_page + 1) % RECORDS_PER_PAGE;
      fill        = 0;
      byte_sum    = 8'h00;
    endfunction

    // Encode one accepted byte and queue the words it produces.
    function void take_byte(logic [7:0] b, logic fin);
      int unsigned n_words;
      int unsigned cnt;
      hex_word_t   w;
      line_text.delete();
      if (fill < BYTES_PER_RECORD) begin
        rec_buf[fill] = b;
        fill++;
        byte_sum = byte_sum + b;
      end
      if (fill >= BYTES_PER_RECORD) emit_record();
      if (fin) begin
        if (fill > 0) emit_record();
        put_str(":00000001FF");
        start_file();
      end
      n_words = (line_text.size() + 3) / 4;
      for (int k = 0; k < n_words; k++) begin
        cnt = line_text.size() - 4 * k;
        if (cnt > 4) cnt = 4;
        w.data = '0;  // unused chars and the pad stay zero
        for (int j = 0; j < cnt; j++) w.data[8*j +: 8] = line_text[4*k + j];
        w.data[34:32] = 3'(cnt);
        w.last = (k == n_words - 1);
        w.done = fin && (k == n_words - 1);
        expected_words.push_back(w);
      end
    endfunction

    function void compare(string name, logic [7:0] exp_v, logic [7:0] act_v);
      if (act_v !== exp_v) begin
        $error("%s: expected %0h, actual %0h", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_word(logic [39:0] data, logic last, logic done);
      hex_word_t w;
      if (expected_words.size() == 0) begin
        $error("unexpected word: tdata %0h tlast %b tuser %b", data, last, done);
        errors++;
        return;
      end
      w = expected_words.pop_front();
      compare("char_a", w.data[7:0], data[7:0]);
      compare("char_b", w.data[15:8], data[15:8]);
      compare("char_c", w.data[23:16], data[23:16]);
      compare("char_d", w.data[31:24], data[31:24]);
      compare("char_count", 8'(w.data[34:32]), 8'(data[34:32]));
      compare("tdata_pad", 8'(w.data[39:35]), 8'(data[39:35]));
      compare("run_last", 8'(w.last), 8'(last));
      compare("file_done", 8'(w.done), 8'(done));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic [0:0]  m_axis_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = 16'h0000;

  // idling knobs, percent of cycles
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  // long hold-off: main bumps hold_reqs, the receiver counts the stretch
  int unsigned hold_reqs = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;

  int unsigned cycle_count = 0;

  hex_line_scoreboard model = new();

  paged_intel_hex_encoder_core dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: any hang ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT) begin
      $display("tb_paged_intel_hex_encoder_core: FAIL");
      $finish;
    end
  end

  // Receiver: checks each word taken at this edge (pre-edge values), then
  // picks tready for the next cycle: long hold, random stall or ready.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid === 1'b1 && m_axis_tready)
        model.check_word(m_axis_tdata, m_axis_tlast, m_axis_tuser[0]);
      if (hold_left != 0) begin
        m_axis_tready <= 1'b0;
        hold_left     <= hold_left - 1;
      end else if (hold_seen != hold_reqs) begin
        m_axis_tready <= 1'b0;
        hold_left     <= HOLD_LEN;
        hold_seen     <= hold_reqs;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // Offer one byte, with random idle cycles ahead of it. tvalid is left high
  // on return so back-to-back words need no second assignment in a step.
  task automatic send_byte(input logic [7:0] b, input logic fin);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= fin;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    model.take_byte(b, fin);
  endtask

  // Drop tvalid, let every queued word arrive, then let the core settle:
  // a byte that closed nothing may still be finishing inside.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (model.expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_base(input logic [15:0] value);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    model.set_base(value);
  endtask

  initial begin
    logic [15:0] phase_base [4];
    int unsigned sent;
    int unsigned flen;

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: one-byte files at the byte extremes under the reset base,
    // a short record flushed by the final byte, then both base extremes.
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h80, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'h01, 1'b1);
    write_base(16'hFFFF);
    send_byte(8'hA5, 1'b1);
    send_byte(8'h5A, 1'b0);
    send_byte(8'h3C, 1'b1);
    write_base(16'h0000);
    send_byte(8'hC3, 1'b0);
    send_byte(8'h96, 1'b1);

    // Base written mid-page: the open page keeps stepping from the old base.
    for (int i = 0; i < MID_HEAD; i++) send_byte(8'($urandom), 1'b0);
    write_base(16'h2000);
    for (int i = 1; i <= MID_TAIL; i++) send_byte(8'($urandom), i == MID_TAIL);

    // Random files under four idling modes. 0xFFE0 makes the address wrap
    // on the second record.
    phase_base[0] = 16'hFFE0;
    phase_base[1] = 16'($urandom_range(0, 16'hFFFF));
    phase_base[2] = 16'h7FF0;
    phase_base[3] = 16'($urandom_range(0, 16'hFFFF));
    for (int ph = 0; ph < 4; ph++) begin
      write_base(phase_base[ph]);
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 78; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 78; end
        default: begin send_idle_pct = 12; recv_stall_pct = 12; end
      endcase
      // back-pressure: receiver holds off while the sender keeps offering
      if (ph == 0) hold_reqs <= hold_reqs + 1;
      sent = 0;
      while (sent < PHASE_BYTES) begin
        // now and then lengths around the record size, else anything from 1 to 80
        if ($urandom_range(0, 3) == 0) begin
          case ($urandom_range(0, 4))
            0: flen = 31;
            1: flen = 32;
            2: flen = 33;
            3: flen = 64;
            default: flen = 65;
          endcase
        end else begin
          flen = $urandom_range(1, 80);
        end
        if (flen > PHASE_BYTES - sent) flen = PHASE_BYTES - sent;
        // an early final byte now and then cuts a file short
        for (int i = 1; i <= flen; i++)
          send_byte(8'($urandom), (i == flen) || ($urandom_range(0, 49) == 0));
        sent += flen;
      end
    end

    wait_idle();
    if (model.expected_words.size() != 0) begin
      $error("%0d expected words never arrived", model.expected_words.size());
      model.errors++;
    end
    if (model.errors == 0) begin
      $display("tb_paged_intel_hex_encoder_core: PASS");
    end else begin
      $display("tb_paged_intel_hex_encoder_core: FAIL");
    end
    $finish;
  end

endmodule
